// ----- rtl/spmq_pkg.sv -----
// spmq_pkg: shared types and codes for the stable min-first priority queue
// used by spmq_cell and stable_min_priority_queue; no dependencies
package spmq_pkg;

    localparam int KEY_W   = 32;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 7;

    localparam logic       OP_INSERT = 1'b0;
    localparam logic       OP_REMOVE = 1'b1;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;

    typedef struct packed {
        logic              op;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] payload;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [KEY_W-1:0]   key_out;
        logic [DATA_W-1:0]  payload_out;
        logic [COUNT_W-1:0] entry_count;
    } t_out_item;

    // contents of one slot of the sorted chain
    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] payload;
    } t_entry;

    // command broadcast to every cell in a cycle
    typedef struct packed {
        logic              ins;
        logic              rem;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] payload;
    } t_cell_cmd;

endpackage

// ----- rtl/spmq_cell.sv -----
// spmq_cell: one slot of the sorted chain, compare against the new key and shift
// depends on spmq_pkg
module spmq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  spmq_pkg::t_cell_cmd i_cmd,
    input  spmq_pkg::t_entry   i_left,
    input  logic               i_left_after,
    input  spmq_pkg::t_entry   i_right,
    output spmq_pkg::t_entry   o_entry,
    output logic               o_after
);
    import spmq_pkg::*;

    logic              r_valid;
    logic [KEY_W-1:0]  r_key;
    logic [DATA_W-1:0] r_payload;
    t_entry            n_entry;

    // new key lands behind this slot, equal keys included so ties stay fifo
    assign o_after = r_valid && (r_key <= i_cmd.key);
    assign o_entry = '{valid: r_valid, key: r_key, payload: r_payload};

    always_comb begin
        n_entry = o_entry;
        if (i_cmd.ins) begin
            if (!o_after) begin
                if (i_left_after) begin
                    n_entry = '{valid: 1'b1, key: i_cmd.key, payload: i_cmd.payload};
                end else begin
                    n_entry = i_left;
                end
            end
        end else if (i_cmd.rem) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_entry.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_entry.key;
        r_payload <= n_entry.payload;
    end

endmodule

// ----- rtl/stable_min_priority_queue.sv -----
// stable_min_priority_queue: sorted chain of spmq_cell slots, head at slot 0
// depends on spmq_pkg and spmq_cell
//
//   channel | beat type  | handshake
//   in      | t_in_item  | i_in_valid / o_in_stall
//   out     | t_out_item | o_out_valid / i_out_stall
//
// one beat per cycle while the input is not stalled: every slot compares its key with
// the new key and either holds, takes the new entry or takes a neighbor's entry in the same cycle
// the result sits in an output register from the cycle after the input beat
// input stalls only while a result waits and the output side is stalled
// synchronous active-low reset empties the chain and the output register
module stable_min_priority_queue #(
    parameter int CAPACITY = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  spmq_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output spmq_pkg::t_out_item o_out_data
);
    import spmq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    t_entry    w_entry [CAPACITY];
    logic      w_after [CAPACITY];
    t_cell_cmd w_cmd;

    logic          r_out_valid;
    t_out_item     r_out;
    t_out_item     n_out;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          w_accept;
    logic          w_full;
    logic          w_empty;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_full      = (r_count == CW'(CAPACITY));
    assign w_empty     = (r_count == '0);

    assign w_cmd.ins     = w_accept && (i_in_data.op == OP_INSERT) && !w_full;
    assign w_cmd.rem     = w_accept && (i_in_data.op == OP_REMOVE) && !w_empty;
    assign w_cmd.key     = i_in_data.key;
    assign w_cmd.payload = i_in_data.payload;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        logic   w_left_after;

        if (g == 0) begin : g_head
            assign w_left       = '0;
            assign w_left_after = 1'b1;
        end else begin : g_mid
            assign w_left       = w_entry[g-1];
            assign w_left_after = w_after[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_body
            assign w_right = w_entry[g+1];
        end

        spmq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_left       (w_left),
            .i_left_after (w_left_after),
            .i_right      (w_right),
            .o_entry      (w_entry[g]),
            .o_after      (w_after[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (w_cmd.ins) begin
            n_count = r_count + CW'(1);
        end else if (w_cmd.rem) begin
            n_count = r_count - CW'(1);
        end
    end

    always_comb begin
        n_out.status      = ST_DONE;
        n_out.key_out     = '0;
        n_out.payload_out = '0;
        n_out.entry_count = COUNT_W'(n_count);
        if (i_in_data.op == OP_INSERT) begin
            if (w_full) begin
                n_out.status = ST_FULL;
            end
        end else if (w_empty) begin
            n_out.status = ST_EMPTY;
        end else begin
            n_out.key_out     = w_entry[0].key;
            n_out.payload_out = w_entry[0].payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
